// ----- rtl/ssfbt_pkg.sv -----
// Package with sizes, command and status codes and shared types of the free block table.
package ssfbt_pkg;
   localparam int MAX_BLOCKS  = 64;
   localparam int HANDLE_BITS = 16;
   localparam int SIZE_BITS   = 20;
   localparam int IDX_BITS    = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS    = $clog2(MAX_BLOCKS + 1);
   localparam int ENTRY_BITS  = HANDLE_BITS + SIZE_BITS;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIT    = 2'd2,
      CMD_LAST   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_LAST,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_BITS-1:0]   waddr;
      logic [ENTRY_BITS-1:0] wdata;
      logic [IDX_BITS-1:0]   raddr;
   } mem_req_type;
endpackage

// ----- rtl/ssfbt_slot_ram.sv -----
// Slot memory with one write port and one registered read port, holding handle and size of each entry.
module ssfbt_slot_ram (
   input  logic                                  clock,
   input  ssfbt_pkg::mem_req_type                mem_req,
   output logic [ssfbt_pkg::ENTRY_BITS-1:0]      rdata
);
   logic [ssfbt_pkg::ENTRY_BITS-1:0] mem [ssfbt_pkg::MAX_BLOCKS];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata <= mem[mem_req.raddr];
   end
endmodule

// ----- rtl/ssfbt_ctrl.sv -----
// Sequencer that scans, shifts and answers commands against the slot memory.
module ssfbt_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [ssfbt_pkg::HANDLE_BITS-1:0]   req_block_handle,
   input  logic [ssfbt_pkg::SIZE_BITS-1:0]     req_block_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [ssfbt_pkg::HANDLE_BITS-1:0]   rsp_found_handle,
   output logic [ssfbt_pkg::SIZE_BITS-1:0]     rsp_found_size,
   output ssfbt_pkg::mem_req_type              mem_req,
   input  logic [ssfbt_pkg::ENTRY_BITS-1:0]    rdata
);
   localparam int IB = ssfbt_pkg::IDX_BITS;
   localparam int CB = ssfbt_pkg::CNT_BITS;
   localparam int HB = ssfbt_pkg::HANDLE_BITS;
   localparam int SB = ssfbt_pkg::SIZE_BITS;

   ssfbt_pkg::state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] pos_ff, pos_in;
   logic [CB-1:0] ptr_ff, ptr_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [HB-1:0] hnd_ff, hnd_in;
   logic [SB-1:0] size_ff, size_in;
   logic [1:0] st_ff, st_in;
   logic [HB-1:0] oh_ff, oh_in;
   logic [SB-1:0] os_ff, os_in;
   logic rv_ff, rv_in;

   logic [HB-1:0] r_hnd;
   logic [SB-1:0] r_size;
   logic [CB-1:0] last_idx;

   assign r_hnd  = rdata[ssfbt_pkg::ENTRY_BITS-1:SB];
   assign r_size = rdata[SB-1:0];
   assign last_idx = count_ff - CB'(1);

   assign req_ready = (state_ff == ssfbt_pkg::S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_found_handle = oh_ff;
   assign rsp_found_size = os_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssfbt_pkg::S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      pos_ff  <= pos_in;
      ptr_ff  <= ptr_in;
      cmd_ff  <= cmd_in;
      hnd_ff  <= hnd_in;
      size_ff <= size_in;
      st_ff   <= st_in;
      oh_ff   <= oh_in;
      os_ff   <= os_in;
   end

   // The scan reads slot ptr each cycle; rdata holds slot pos, read in the cycle before.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      ptr_in = ptr_ff;
      cmd_in = cmd_ff;
      hnd_in = hnd_ff;
      size_in = size_ff;
      st_in = st_ff;
      oh_in = oh_ff;
      os_in = os_ff;
      rv_in = rv_ff;
      mem_req = '0;
      mem_req.raddr = ptr_ff[IB-1:0];
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ssfbt_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in = req_command;
               hnd_in = req_block_handle;
               size_in = req_block_size;
               oh_in = '0;
               os_in = '0;
               st_in = ssfbt_pkg::ST_OK;
               pos_in = '0;
               ptr_in = '0;
               mem_req.raddr = '0;
               case (ssfbt_pkg::cmd_type'(req_command))
                  ssfbt_pkg::CMD_INSERT: begin
                     if (count_ff == CB'(ssfbt_pkg::MAX_BLOCKS)) begin
                        st_in = ssfbt_pkg::ST_FULL;
                        state_in = ssfbt_pkg::S_DONE;
                     end else begin
                        state_in = ssfbt_pkg::S_SCAN;
                     end
                  end
                  ssfbt_pkg::CMD_LAST: begin
                     if (count_ff == '0) begin
                        st_in = ssfbt_pkg::ST_MISS;
                        state_in = ssfbt_pkg::S_DONE;
                     end else begin
                        ptr_in = last_idx;
                        mem_req.raddr = last_idx[IB-1:0];
                        state_in = ssfbt_pkg::S_LAST;
                     end
                  end
                  default: begin
                     state_in = ssfbt_pkg::S_SCAN;
                  end
               endcase
               if (state_in == ssfbt_pkg::S_SCAN) begin
                  ptr_in = CB'(1);
               end
            end
         end
         ssfbt_pkg::S_SCAN: begin
            ptr_in = ptr_ff + CB'(1);
            if (pos_ff >= count_ff) begin
               case (ssfbt_pkg::cmd_type'(cmd_ff))
                  ssfbt_pkg::CMD_INSERT: begin
                     mem_req.we = 1'b1;
                     mem_req.waddr = pos_ff[IB-1:0];
                     mem_req.wdata = {hnd_ff, size_ff};
                     count_in = count_ff + CB'(1);
                  end
                  default: st_in = ssfbt_pkg::ST_MISS;
               endcase
               state_in = ssfbt_pkg::S_DONE;
            end else begin
               case (ssfbt_pkg::cmd_type'(cmd_ff))
                  ssfbt_pkg::CMD_INSERT: begin
                     if (r_size > size_ff) begin
                        // Move entries pos..count-1 up by one, from the top.
                        ptr_in = last_idx;
                        mem_req.raddr = last_idx[IB-1:0];
                        state_in = ssfbt_pkg::S_SHIFT_UP;
                     end else begin
                        pos_in = pos_ff + CB'(1);
                     end
                  end
                  ssfbt_pkg::CMD_REMOVE: begin
                     if (r_hnd == hnd_ff) begin
                        count_in = count_ff - CB'(1);
                        state_in = ssfbt_pkg::S_SHIFT_DOWN;
                     end else begin
                        pos_in = pos_ff + CB'(1);
                     end
                  end
                  default: begin
                     if (r_size >= size_ff) begin
                        oh_in = r_hnd;
                        os_in = r_size;
                        state_in = ssfbt_pkg::S_DONE;
                     end else begin
                        pos_in = pos_ff + CB'(1);
                     end
                  end
               endcase
            end
         end
         ssfbt_pkg::S_SHIFT_UP: begin
            // rdata holds slot ptr_ff from the previous read; it is written to slot ptr_ff + 1.
            mem_req.we = 1'b1;
            mem_req.waddr = IB'(ptr_ff + CB'(1));
            mem_req.wdata = rdata;
            if (ptr_ff == pos_ff) begin
               state_in = ssfbt_pkg::S_DONE;
               count_in = count_ff + CB'(1);
               st_in = ssfbt_pkg::ST_OK;
               ptr_in = ptr_ff;
            end else begin
               ptr_in = ptr_ff - CB'(1);
               mem_req.raddr = IB'(ptr_ff - CB'(1));
            end
         end
         ssfbt_pkg::S_SHIFT_DOWN: begin
            // ptr_ff is the slot being read, and its data lands at ptr_ff - 1 next cycle.
            if (ptr_ff > count_ff + CB'(1)) begin
               state_in = ssfbt_pkg::S_DONE;
            end else begin
               mem_req.we = (ptr_ff > pos_ff + CB'(1));
               mem_req.waddr = IB'(ptr_ff - CB'(2));
               mem_req.wdata = rdata;
               ptr_in = ptr_ff + CB'(1);
               mem_req.raddr = ptr_ff[IB-1:0];
            end
         end
         ssfbt_pkg::S_LAST: begin
            oh_in = r_hnd;
            os_in = r_size;
            state_in = ssfbt_pkg::S_DONE;
         end
         ssfbt_pkg::S_DONE: begin
            if (cmd_ff == ssfbt_pkg::CMD_INSERT && st_ff == ssfbt_pkg::ST_OK
                  && state_ff == ssfbt_pkg::S_DONE && pos_ff < count_ff
                  && ptr_ff == pos_ff && count_ff != '0) begin
               mem_req.we = 1'b1;
               mem_req.waddr = pos_ff[IB-1:0];
               mem_req.wdata = {hnd_ff, size_ff};
               ptr_in = ~CB'(0);
            end
            rv_in = 1'b1;
            state_in = ssfbt_pkg::S_IDLE;
         end
         default: state_in = ssfbt_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(ssfbt_pkg::MAX_BLOCKS))
      else $error("entry count out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ssfbt_pkg::S_IDLE) |-> !req_ready)
      else $error("ready while busy");
   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && st_ff == ssfbt_pkg::ST_FULL) |-> (count_ff == CB'(ssfbt_pkg::MAX_BLOCKS)))
      else $error("full status without full table");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssfbt_pkg::S_DONE) |=> rv_ff)
      else $error("done without response");
`endif
endmodule

// ----- rtl/size_sorted_free_block_table.sv -----
// Top level of the size sorted free block table: best fit free list in ordered slots.
//  channel  | ports                                         | direction
//  request  | req_valid/ready, command, block_handle, size   | in
//  response | rsp_valid/ready, status, found_handle, size    | out
// The work of a transaction is bounded by the one read and one write port of the slot
// memory: a scan to the matching slot, then for an insert or a remove a shift of the slots
// above it, one slot per cycle. A full insert and a last answer without a scan.
// Reset empties the table at once; slot contents are not cleared.
// A new request is taken only after the previous response has been accepted.
module size_sorted_free_block_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [ssfbt_pkg::HANDLE_BITS-1:0]   req_block_handle,
   input  logic [ssfbt_pkg::SIZE_BITS-1:0]     req_block_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [ssfbt_pkg::HANDLE_BITS-1:0]   rsp_found_handle,
   output logic [ssfbt_pkg::SIZE_BITS-1:0]     rsp_found_size
);
   ssfbt_pkg::mem_req_type mem_req;
   logic [ssfbt_pkg::ENTRY_BITS-1:0] rdata;

   ssfbt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_block_handle,
      .req_block_size, .rsp_valid, .rsp_ready, .rsp_status, .rsp_found_handle,
      .rsp_found_size, .mem_req, .rdata
   );

   ssfbt_slot_ram u_ram (.clock, .mem_req, .rdata);
endmodule
